// ===== hdl/quad_warp_point_map_unit_defines.svh =====
// ----------------------------------------------------------------------------
// quad warp point map assertion macros
// Concurrent checks on clk with synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef QUAD_WARP_POINT_MAP_UNIT_DEFINES_SVH
`define QUAD_WARP_POINT_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define QWP_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quad warp point map check failed");
// next-cycle implication
`define QWP_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quad warp point map check failed");
`else
`define QWP_CHECK(lbl, ante, cons)
`define QWP_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/qwp_pkg.sv =====
// ----------------------------------------------------------------------------
// qwp_pkg
// Shared constants of the quad warp point map unit.
// ----------------------------------------------------------------------------
package qwp_pkg;

  // register stages inside the edge and cross-product block
  localparam int GEOM_STAGES = 5;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BL   = 3'd7;

endpackage

// ===== hdl/qwp_div_pipe.sv =====
// ----------------------------------------------------------------------------
// qwp_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module qwp_div_pipe #(
  parameter int DW = 33,
  parameter int VW = 16,
  parameter int QW = 18,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic          out_rem_nz,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);
  import qwp_pkg::*;

  localparam int HW = DW - QW;
  localparam int XW = (HW > VW) ? HW : VW;

  logic          v_r    [QW+1];
  logic [VW-1:0] rem_r  [QW+1];
  logic [QW-1:0] low_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic [VW-1:0] den_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];
  logic          ovf_r  [QW+1];

  logic [HW-1:0] num_hi;
  logic          ovf0;

  // quotient would not fit in QW bits
  assign num_hi = in_num[DW-1:QW];
  assign ovf0   = XW'(num_hi) >= XW'(in_den);

  // stage 0: load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= VW'(num_hi);
    low_r[0]  <= in_num[QW-1:0];
    q_r[0]    <= '0;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    ovf_r[0]  <= ovf0;
  end

  // one shift-compare-subtract step per stage
  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    assign trial = {rem_r[i-1], low_r[i-1][QW-1]};
    assign diff  = trial - {1'b0, den_r[i-1]};
    assign ge    = trial >= {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
      low_r[i]  <= low_r[i-1] << 1;
      q_r[i]    <= {q_r[i-1][QW-2:0], ge};
      den_r[i]  <= den_r[i-1];
      side_r[i] <= side_r[i-1];
      ovf_r[i]  <= ovf_r[i-1];
    end
  end

  assign out_valid  = v_r[QW];
  assign out_quot   = q_r[QW];
  assign out_rem_nz = |rem_r[QW];
  assign out_ovf    = ovf_r[QW];
  assign out_side   = side_r[QW];

endmodule

// ===== hdl/qwp_geom.sv =====
// ----------------------------------------------------------------------------
// qwp_geom
// Edge interpolation at u and v, then the cross products of the two lines.
// ----------------------------------------------------------------------------
module qwp_geom #(
  parameter int CW = 16,
  parameter int FW = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [FW+1:0]    in_u,
  input  logic signed [FW+1:0]    in_v,
  input  logic signed [CW-1:0]    in_cx [4],
  input  logic signed [CW-1:0]    in_cy [4],
  output logic                    out_valid,
  output logic signed [CW+2:0]    out_tx,
  output logic signed [CW+2:0]    out_ty,
  output logic signed [CW+3:0]    out_d1x,
  output logic signed [CW+3:0]    out_d1y,
  output logic signed [2*CW+8:0]  out_den,
  output logic signed [2*CW+8:0]  out_num
);
  import qwp_pkg::*;

  localparam int LW  = CW + 3;
  localparam int DW  = LW + 1;
  localparam int MW  = 2 * DW;
  localparam int PW  = MW + 1;
  localparam int PRW = CW + FW + 3;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FW - 1);

  logic                  v_r [GEOM_STAGES];
  logic signed [CW-1:0]  la [8];
  logic signed [CW-1:0]  lb [8];
  logic signed [FW+1:0]  lf [8];

  logic signed [PRW-1:0] g1_prod_r [8];
  logic signed [CW-1:0]  g1_base_r [8];
  logic signed [LW-1:0]  g2_lerp_r [8];
  logic signed [LW-1:0]  g3_tx_r, g3_ty_r;
  logic signed [DW-1:0]  g3_d1x_r, g3_d1y_r, g3_d2x_r, g3_d2y_r, g3_ex_r, g3_ey_r;
  logic signed [LW-1:0]  g4_tx_r, g4_ty_r;
  logic signed [DW-1:0]  g4_d1x_r, g4_d1y_r;
  logic signed [MW-1:0]  g4_p1_r, g4_p2_r, g4_p3_r, g4_p4_r;
  logic signed [LW-1:0]  g5_tx_r, g5_ty_r;
  logic signed [DW-1:0]  g5_d1x_r, g5_d1y_r;
  logic signed [PW-1:0]  g5_den_r, g5_num_r;

  // edge end points: top, bottom at u; left, right at v
  always_comb begin
    la[0] = in_cx[0]; lb[0] = in_cx[1]; lf[0] = in_u;
    la[1] = in_cy[0]; lb[1] = in_cy[1]; lf[1] = in_u;
    la[2] = in_cx[3]; lb[2] = in_cx[2]; lf[2] = in_u;
    la[3] = in_cy[3]; lb[3] = in_cy[2]; lf[3] = in_u;
    la[4] = in_cx[0]; lb[4] = in_cx[3]; lf[4] = in_v;
    la[5] = in_cy[0]; lb[5] = in_cy[3]; lf[5] = in_v;
    la[6] = in_cx[1]; lb[6] = in_cx[2]; lf[6] = in_v;
    la[7] = in_cy[1]; lb[7] = in_cy[2]; lf[7] = in_v;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GEOM_STAGES; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 1; i < GEOM_STAGES; i++) v_r[i] <= v_r[i-1];
    end
  end

  // g1: edge delta times fraction
  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      g1_prod_r[k] <= (PRW'(lb[k]) - PRW'(la[k])) * PRW'(lf[k]);
      g1_base_r[k] <= la[k];
    end
  end

  // g2: round half up and add the start point
  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      g2_lerp_r[k] <= LW'(g1_base_r[k]) + LW'((g1_prod_r[k] + HALF) >>> FW);
    end
  end

  // g3: line directions and offset between the two lines
  always_ff @(posedge clk) begin
    g3_tx_r  <= g2_lerp_r[0];
    g3_ty_r  <= g2_lerp_r[1];
    g3_d1x_r <= DW'(g2_lerp_r[2]) - DW'(g2_lerp_r[0]);
    g3_d1y_r <= DW'(g2_lerp_r[3]) - DW'(g2_lerp_r[1]);
    g3_d2x_r <= DW'(g2_lerp_r[6]) - DW'(g2_lerp_r[4]);
    g3_d2y_r <= DW'(g2_lerp_r[7]) - DW'(g2_lerp_r[5]);
    g3_ex_r  <= DW'(g2_lerp_r[4]) - DW'(g2_lerp_r[0]);
    g3_ey_r  <= DW'(g2_lerp_r[5]) - DW'(g2_lerp_r[1]);
  end

  // g4: cross product terms
  always_ff @(posedge clk) begin
    g4_tx_r  <= g3_tx_r;
    g4_ty_r  <= g3_ty_r;
    g4_d1x_r <= g3_d1x_r;
    g4_d1y_r <= g3_d1y_r;
    g4_p1_r  <= MW'(g3_d1x_r) * MW'(g3_d2y_r);
    g4_p2_r  <= MW'(g3_d1y_r) * MW'(g3_d2x_r);
    g4_p3_r  <= MW'(g3_ex_r) * MW'(g3_d2y_r);
    g4_p4_r  <= MW'(g3_ey_r) * MW'(g3_d2x_r);
  end

  // g5: denominator and numerator
  always_ff @(posedge clk) begin
    g5_tx_r  <= g4_tx_r;
    g5_ty_r  <= g4_ty_r;
    g5_d1x_r <= g4_d1x_r;
    g5_d1y_r <= g4_d1y_r;
    g5_den_r <= PW'(g4_p1_r) - PW'(g4_p2_r);
    g5_num_r <= PW'(g4_p3_r) - PW'(g4_p4_r);
  end

  assign out_valid = v_r[GEOM_STAGES-1];
  assign out_tx    = g5_tx_r;
  assign out_ty    = g5_ty_r;
  assign out_d1x   = g5_d1x_r;
  assign out_d1y   = g5_d1y_r;
  assign out_den   = g5_den_r;
  assign out_num   = g5_num_r;

endmodule

// ===== hdl/quad_warp_point_map_unit.sv =====
// Maps a point of the configured source rectangle into the configured
// quadrilateral. The block takes one item per clock while busy is low and
// returns one result per item, in order; the pipeline depth is set mostly by
// the four pipelined restoring dividers, one quotient bit per stage, that form
// u,v and the line intersection. Busy is high only during reset and the cycle
// after it. The out_valid strobe lasts one cycle and cannot be held off, so the
// receiver must take every result.
// Registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
// quad_warp_point_map_unit
// Rectangle to quadrilateral point mapping with saturation and parallel flag.
// ----------------------------------------------------------------------------
`include "quad_warp_point_map_unit_defines.svh"

module quad_warp_point_map_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_WIDTH  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qwp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [2*COORD_WIDTH-1:0]         cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    in_point_x,
  input  logic signed [COORD_WIDTH-1:0]    in_point_y,
  output logic                             out_valid,
  output logic signed [COORD_WIDTH-1:0]    out_mapped_x,
  output logic signed [COORD_WIDTH-1:0]    out_mapped_y,
  output logic                             out_degenerate,
  output logic                             out_clipped
);
  import qwp_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FW   = FRAC_WIDTH;
  localparam int QW1  = FW + 2;
  localparam int NW1  = CW + 1 + FW;
  localparam int LW   = CW + 3;
  localparam int DW   = LW + 1;
  localparam int PW   = 2 * DW + 1;
  localparam int LOW  = (PW + 1) / 2;
  localparam int HIW  = PW - LOW;
  localparam int QPW  = PW + DW;
  localparam int N2W  = QPW + 2;
  localparam int QW2  = CW + 5;
  localparam int RW   = QW2 + 2;
  localparam int SW2  = LW + 2;
  localparam int LAT  = CW + FW + 22;
  localparam logic [FW+2:0] ULIM = (FW+3)'(1) << (FW + 1);
  localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

  // configuration registers
  logic signed [CW-1:0] rect_left_r, rect_top_r;
  logic [CW-1:0]        rect_width_r, rect_height_r;
  logic [2*CW-1:0]      corner_r [4];
  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cy [4];

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_width_r  <= CW'(1024);
      rect_height_r <= CW'(1024);
      corner_r[0]   <= '0;
      corner_r[1]   <= {CW'(1024), CW'(0)};
      corner_r[2]   <= {CW'(1024), CW'(1024)};
      corner_r[3]   <= {CW'(0), CW'(1024)};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECT_LEFT:   rect_left_r   <= cfg_data[CW-1:0];
        REG_RECT_TOP:    rect_top_r    <= cfg_data[CW-1:0];
        REG_RECT_WIDTH:  rect_width_r  <= cfg_data[CW-1:0];
        REG_RECT_HEIGHT: rect_height_r <= cfg_data[CW-1:0];
        REG_CORNER_TL:   corner_r[0]   <= cfg_data;
        REG_CORNER_TR:   corner_r[1]   <= cfg_data;
        REG_CORNER_BR:   corner_r[2]   <= cfg_data;
        REG_CORNER_BL:   corner_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cx[k] = corner_r[k][2*CW-1:CW];
      cy[k] = corner_r[k][CW-1:0];
    end
  end

  // not ready during reset and the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r | ~rst_n;
  assign accept = start & ~busy;

  // stage a: offset from the rectangle origin
  logic                a_v_r;
  logic signed [CW:0]  a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r <= (CW+1)'(in_point_x) - (CW+1)'(rect_left_r);
    a_dy_r <= (CW+1)'(in_point_y) - (CW+1)'(rect_top_r);
  end

  // u and v dividers: |d| * 2^F / size
  logic [CW:0]    abs_dx, abs_dy;
  logic [CW-1:0]  wdiv, hdiv;
  logic           du_v;
  logic [QW1-1:0] du_q, dv_q;
  logic           du_nz, dv_nz, du_ovf, dv_ovf;
  logic [0:0]     du_neg, dv_neg;

  assign abs_dx = a_dx_r[CW] ? -a_dx_r : a_dx_r;
  assign abs_dy = a_dy_r[CW] ? -a_dy_r : a_dy_r;
  assign wdiv   = (rect_width_r == '0) ? CW'(1) : rect_width_r;
  assign hdiv   = (rect_height_r == '0) ? CW'(1) : rect_height_r;

  qwp_div_pipe #(.DW(NW1), .VW(CW), .QW(QW1), .SW(1)) u_div_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (a_v_r),
    .in_num     ({abs_dx, FW'(0)}),
    .in_den     (wdiv),
    .in_side    (a_dx_r[CW]),
    .out_valid  (du_v),
    .out_quot   (du_q),
    .out_rem_nz (du_nz),
    .out_ovf    (du_ovf),
    .out_side   (du_neg)
  );

  qwp_div_pipe #(.DW(NW1), .VW(CW), .QW(QW1), .SW(1)) u_div_v (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (a_v_r),
    .in_num     ({abs_dy, FW'(0)}),
    .in_den     (hdiv),
    .in_side    (a_dy_r[CW]),
    .out_valid  (),
    .out_quot   (dv_q),
    .out_rem_nz (dv_nz),
    .out_ovf    (dv_ovf),
    .out_side   (dv_neg)
  );

  // floor and clamp to the Q2.F range
  function automatic logic signed [FW+1:0] norm_fix(input logic [QW1-1:0] q,
                                                    input logic nz, input logic ovf,
                                                    input logic neg);
    logic [FW+2:0] mag;
    logic [FW+2:0] res;
    mag = neg ? ((FW+3)'(q) + (FW+3)'(nz)) : (FW+3)'(q);
    if (neg) begin
      res = (ovf || mag > ULIM) ? -ULIM : -mag;
    end else begin
      res = (ovf || mag > ULIM - 1'b1) ? ULIM - 1'b1 : mag;
    end
    return res[FW+1:0];
  endfunction

  logic                  c_v_r;
  logic signed [FW+1:0]  c_u_r, c_vv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= du_v;
    end
  end

  always_ff @(posedge clk) begin
    c_u_r  <= norm_fix(du_q, du_nz, du_ovf, du_neg[0]);
    c_vv_r <= norm_fix(dv_q, dv_nz, dv_ovf, dv_neg[0]);
  end

  // edge points and cross products
  logic                  g_v;
  logic signed [LW-1:0]  g_tx, g_ty;
  logic signed [DW-1:0]  g_d1x, g_d1y;
  logic signed [PW-1:0]  g_den, g_num;

  qwp_geom #(.CW(CW), .FW(FW)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_v_r),
    .in_u      (c_u_r),
    .in_v      (c_vv_r),
    .in_cx     (cx),
    .in_cy     (cy),
    .out_valid (g_v),
    .out_tx    (g_tx),
    .out_ty    (g_ty),
    .out_d1x   (g_d1x),
    .out_d1y   (g_d1y),
    .out_den   (g_den),
    .out_num   (g_num)
  );

  // s1: parallel test, make the denominator positive
  logic                 s1_v_r, s1_deg_r;
  logic [PW-1:0]        s1_dpos_r;
  logic signed [PW-1:0] s1_npos_r;
  logic signed [LW-1:0] s1_tx_r, s1_ty_r;
  logic signed [DW-1:0] s1_d1x_r, s1_d1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_deg_r  <= (g_den == '0);
    s1_dpos_r <= g_den[PW-1] ? -g_den : g_den;
    s1_npos_r <= g_den[PW-1] ? -g_num : g_num;
    s1_tx_r   <= g_tx;
    s1_ty_r   <= g_ty;
    s1_d1x_r  <= g_d1x;
    s1_d1y_r  <= g_d1y;
  end

  // s2: num times direction, split into two partial products
  logic                        s2_v_r, s2_deg_r;
  logic [PW-1:0]               s2_dpos_r;
  logic signed [LW-1:0]        s2_tx_r, s2_ty_r;
  logic signed [LOW+DW:0]      s2_plo_x_r, s2_plo_y_r;
  logic signed [HIW+DW-1:0]    s2_phi_x_r, s2_phi_y_r;
  logic signed [LOW:0]         npos_lo;
  logic signed [HIW-1:0]       npos_hi;

  assign npos_lo = $signed({1'b0, s1_npos_r[LOW-1:0]});
  assign npos_hi = s1_npos_r[PW-1:LOW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_deg_r   <= s1_deg_r;
    s2_dpos_r  <= s1_dpos_r;
    s2_tx_r    <= s1_tx_r;
    s2_ty_r    <= s1_ty_r;
    s2_plo_x_r <= (LOW+DW+1)'(npos_lo) * (LOW+DW+1)'(s1_d1x_r);
    s2_plo_y_r <= (LOW+DW+1)'(npos_lo) * (LOW+DW+1)'(s1_d1y_r);
    s2_phi_x_r <= (HIW+DW)'(npos_hi) * (HIW+DW)'(s1_d1x_r);
    s2_phi_y_r <= (HIW+DW)'(npos_hi) * (HIW+DW)'(s1_d1y_r);
  end

  // s3: 2 * num * d1 + den
  logic                 s3_v_r, s3_deg_r;
  logic [PW-1:0]        s3_dpos_r;
  logic signed [LW-1:0] s3_tx_r, s3_ty_r;
  logic signed [N2W-1:0] s3_n2x_r, s3_n2y_r;
  logic signed [N2W-1:0] dpos_ext;

  assign dpos_ext = N2W'($signed({1'b0, s2_dpos_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_deg_r  <= s2_deg_r;
    s3_dpos_r <= s2_dpos_r;
    s3_tx_r   <= s2_tx_r;
    s3_ty_r   <= s2_ty_r;
    s3_n2x_r  <= (N2W'(s2_phi_x_r) <<< (LOW + 1)) + (N2W'(s2_plo_x_r) <<< 1) + dpos_ext;
    s3_n2y_r  <= (N2W'(s2_phi_y_r) <<< (LOW + 1)) + (N2W'(s2_plo_y_r) <<< 1) + dpos_ext;
  end

  // s4: sign and magnitude for the dividers
  logic                 s4_v_r, s4_deg_r;
  logic [PW-1:0]        s4_dpos_r;
  logic signed [LW-1:0] s4_tx_r, s4_ty_r;
  logic [N2W-2:0]       s4_mx_r, s4_my_r;
  logic                 s4_nx_r, s4_ny_r;
  logic signed [N2W-1:0] n2x_abs, n2y_abs;

  assign n2x_abs = s3_n2x_r[N2W-1] ? -s3_n2x_r : s3_n2x_r;
  assign n2y_abs = s3_n2y_r[N2W-1] ? -s3_n2y_r : s3_n2y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_deg_r  <= s3_deg_r;
    s4_dpos_r <= s3_dpos_r;
    s4_tx_r   <= s3_tx_r;
    s4_ty_r   <= s3_ty_r;
    s4_mx_r   <= n2x_abs[N2W-2:0];
    s4_my_r   <= n2y_abs[N2W-2:0];
    s4_nx_r   <= s3_n2x_r[N2W-1];
    s4_ny_r   <= s3_n2y_r[N2W-1];
  end

  // intersection dividers: (2 num d1 + den) / (2 den)
  logic           dx_v;
  logic [QW2-1:0] dx_q, dy_q;
  logic           dx_nz, dy_nz, dx_ovf, dy_ovf;
  logic [SW2-1:0] dx_side, dy_side;

  qwp_div_pipe #(.DW(N2W-1), .VW(PW+1), .QW(QW2), .SW(SW2)) u_div_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s4_v_r),
    .in_num     (s4_mx_r),
    .in_den     ({s4_dpos_r, 1'b0}),
    .in_side    ({s4_deg_r, s4_nx_r, s4_tx_r}),
    .out_valid  (dx_v),
    .out_quot   (dx_q),
    .out_rem_nz (dx_nz),
    .out_ovf    (dx_ovf),
    .out_side   (dx_side)
  );

  qwp_div_pipe #(.DW(N2W-1), .VW(PW+1), .QW(QW2), .SW(SW2)) u_div_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s4_v_r),
    .in_num     (s4_my_r),
    .in_den     ({s4_dpos_r, 1'b0}),
    .in_side    ({s4_deg_r, s4_ny_r, s4_ty_r}),
    .out_valid  (),
    .out_quot   (dy_q),
    .out_rem_nz (dy_nz),
    .out_ovf    (dy_ovf),
    .out_side   (dy_side)
  );

  // floor of the quotient, clamped, added to the base point
  function automatic logic signed [RW-1:0] solve_fix(input logic [QW2-1:0] q,
                                                     input logic nz, input logic ovf,
                                                     input logic [SW2-1:0] side);
    logic [QW2:0]          mag;
    logic signed [RW-1:0]  qs;
    logic signed [LW-1:0]  base;
    base = side[LW-1:0];
    if (ovf) begin
      mag = {1'b0, {QW2{1'b1}}};
    end else begin
      mag = (QW2+1)'(q) + (QW2+1)'(nz & side[LW]);
    end
    qs = $signed({1'b0, mag});
    return RW'(base) + (side[LW] ? -qs : qs);
  endfunction

  logic                 s5_v_r, s5_deg_r;
  logic signed [RW-1:0] s5_rx_r, s5_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= dx_v;
    end
  end

  always_ff @(posedge clk) begin
    s5_deg_r <= dx_side[LW+1];
    s5_rx_r  <= solve_fix(dx_q, dx_nz, dx_ovf, dx_side);
    s5_ry_r  <= solve_fix(dy_q, dy_nz, dy_ovf, dy_side);
  end

  // output register: saturate, zero on parallel lines
  logic                 o_v_r, o_deg_r, o_clip_r;
  logic signed [CW-1:0] o_x_r, o_y_r;
  logic                 clip_x, clip_y;
  logic signed [RW-1:0] sat_x, sat_y;

  always_comb begin
    clip_x = (s5_rx_r > MAXV) || (s5_rx_r < MINV);
    clip_y = (s5_ry_r > MAXV) || (s5_ry_r < MINV);
    sat_x  = (s5_rx_r > MAXV) ? MAXV : ((s5_rx_r < MINV) ? MINV : s5_rx_r);
    sat_y  = (s5_ry_r > MAXV) ? MAXV : ((s5_ry_r < MINV) ? MINV : s5_ry_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    o_deg_r  <= s5_deg_r;
    o_clip_r <= ~s5_deg_r & (clip_x | clip_y);
    o_x_r    <= s5_deg_r ? '0 : sat_x[CW-1:0];
    o_y_r    <= s5_deg_r ? '0 : sat_y[CW-1:0];
  end

  assign out_valid      = o_v_r;
  assign out_mapped_x   = o_x_r;
  assign out_mapped_y   = o_y_r;
  assign out_degenerate = o_deg_r;
  assign out_clipped    = o_clip_r;

  // checks
  `QWP_CHECK(a_item_out, $past(accept, LAT), out_valid)
  `QWP_CHECK(a_no_extra_out, out_valid, $past(accept, LAT))
  `QWP_CHECK_NEXT(a_deg_zero, s5_v_r && s5_deg_r, out_valid && out_degenerate && out_mapped_x == '0 && out_mapped_y == '0 && !out_clipped)
  `QWP_CHECK(a_clip_at_limit, out_valid && out_clipped, out_mapped_x == MAXV[CW-1:0] || out_mapped_x == MINV[CW-1:0] || out_mapped_y == MAXV[CW-1:0] || out_mapped_y == MINV[CW-1:0])

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad warp point map testbench
// Feeds points through several rectangle and quad settings, predicts each
// mapped point with exact wide integer math and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import qwp_pkg::*;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
  } point_t;

  typedef struct {
    logic [15:0] mx;
    logic [15:0] my;
    logic        deg;
    logic        clip;
  } mapped_t;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 70;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic        out_valid;
  logic signed [15:0] out_mapped_x;
  logic signed [15:0] out_mapped_y;
  logic        out_degenerate;
  logic        out_clipped;

  // shadow copy of the configuration
  logic [15:0] sh_left = 16'd0, sh_top = 16'd0, sh_width = 16'd1024, sh_height = 16'd1024;
  logic [31:0] sh_corner [4];

  point_t  pending_points [$];
  mapped_t expected_points [$];
  int      idle_pct = 25;
  int      error_count = 0;
  int      stall_cycles = 0;
  logic    taken = 1'b0;

  quad_warp_point_map_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_mapped_x(out_mapped_x),
    .out_mapped_y(out_mapped_y), .out_degenerate(out_degenerate),
    .out_clipped(out_clipped)
  );

  always #5 clk = ~clk;

  // floor division, positive divisor
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // point position within the rectangle as Q2.16, clamped
  function automatic longint norm_q(longint d, logic [15:0] size);
    longint w, f;
    w = (size == 16'd0) ? 1 : longint'(size);
    f = floor_div(d * 65536, w);
    if (f > 131071) f = 131071;
    if (f < -131072) f = -131072;
    return f;
  endfunction

  function automatic longint edge_pt(longint a, longint b, longint f);
    return a + (((b - a) * f + 32768) >>> 16);
  endfunction

  // base + round(d1c * num / den), quotient magnitude clamped to 2^48
  function automatic longint solve_coord(longint base, longint d1c,
                                         logic signed [127:0] num,
                                         logic signed [127:0] den);
    logic signed [127:0] n2, d2, q;
    n2 = 2 * (num * d1c) + den;
    d2 = 2 * den;
    q = n2 / d2;
    if ((n2 % d2) != 0 && n2 < 0) q = q - 1;
    if (q > (128'sd1 <<< 48)) q = 128'sd1 <<< 48;
    if (q < -(128'sd1 <<< 48)) q = -(128'sd1 <<< 48);
    return base + longint'(q);
  endfunction

  function automatic logic [15:0] sat16(longint v, inout logic clip);
    if (v > 32767) begin
      clip = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic mapped_t map_point(point_t p);
    mapped_t r;
    longint cx [4], cy [4];
    longint u, v, tx, ty, bx, by, lx, ly, rx, ry, d1x, d1y, d2x, d2y;
    logic signed [127:0] den, num;
    logic clip;
    clip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cx[k] = longint'($signed(sh_corner[k][31:16]));
      cy[k] = longint'($signed(sh_corner[k][15:0]));
    end
    u = norm_q(longint'($signed(p.px)) - longint'($signed(sh_left)), sh_width);
    v = norm_q(longint'($signed(p.py)) - longint'($signed(sh_top)), sh_height);
    tx = edge_pt(cx[0], cx[1], u); ty = edge_pt(cy[0], cy[1], u);
    bx = edge_pt(cx[3], cx[2], u); by = edge_pt(cy[3], cy[2], u);
    lx = edge_pt(cx[0], cx[3], v); ly = edge_pt(cy[0], cy[3], v);
    rx = edge_pt(cx[1], cx[2], v); ry = edge_pt(cy[1], cy[2], v);
    d1x = bx - tx; d1y = by - ty;
    d2x = rx - lx; d2y = ry - ly;
    den = 128'(d1x) * 128'(d2y) - 128'(d1y) * 128'(d2x);
    num = 128'(lx - tx) * 128'(d2y) - 128'(ly - ty) * 128'(d2x);
    if (den == 0) begin
      r.mx = '0; r.my = '0; r.deg = 1'b1; r.clip = 1'b0;
      return r;
    end
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    r.mx = sat16(solve_coord(tx, d1x, num, den), clip);
    r.my = sat16(solve_coord(ty, d1y, num, den), clip);
    r.deg = 1'b0;
    r.clip = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        start <= 1'b1;
        in_point_x <= p.px;
        in_point_y <= p.py;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance, result check and watchdog
  always @(posedge clk) begin
    point_t  p;
    mapped_t e;
    logic    moved;
    moved = 1'b0;
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      p.px = in_point_x;
      p.py = in_point_y;
      expected_points.push_back(map_point(p));
      moved = 1'b1;
    end
    if (rst_n && out_valid) begin
      moved = 1'b1;
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_points.pop_front();
        if (out_mapped_x !== e.mx) report_mismatch("mapped_x", out_mapped_x, $signed(e.mx));
        if (out_mapped_y !== e.my) report_mismatch("mapped_y", out_mapped_y, $signed(e.my));
        if (out_degenerate !== e.deg) report_mismatch("degenerate", out_degenerate, e.deg);
        if (out_clipped !== e.clip) report_mismatch("clipped", out_clipped, e.clip);
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_RECT_LEFT:   sh_left = val[15:0];
      REG_RECT_TOP:    sh_top = val[15:0];
      REG_RECT_WIDTH:  sh_width = val[15:0];
      REG_RECT_HEIGHT: sh_height = val[15:0];
      REG_CORNER_TL:   sh_corner[0] = val;
      REG_CORNER_TR:   sh_corner[1] = val;
      REG_CORNER_BR:   sh_corner[2] = val;
      REG_CORNER_BL:   sh_corner[3] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_point(int x, int y);
    point_t p;
    p.px = x[15:0];
    p.py = y[15:0];
    pending_points.push_back(p);
  endtask

  // wait for every item to be taken and every result to come back
  task automatic drain();
    while (pending_points.size() > 0 || start || expected_points.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_corner(int mode);
    logic [15:0] xs [4];
    if (mode == 1) begin
      xs = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
      return {xs[$urandom_range(3)], xs[$urandom_range(3)]};
    end
    if (mode == 2) return {16'($urandom_range(0, 600)), 16'($urandom_range(0, 600))};
    return $urandom;
  endfunction

  initial begin
    int mode, w, h, x0, y0;
    logic [31:0] c;
    sh_corner[0] = 32'h0000_0000;
    sh_corner[1] = 32'h0400_0000;
    sh_corner[2] = 32'h0400_0400;
    sh_corner[3] = 32'h0000_0400;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed points on the reset square
    add_point(0, 0); add_point(1024, 1024); add_point(512, 512); add_point(1023, 1);
    add_point(-32768, -32768); add_point(32767, 32767);
    add_point(32767, -32768); add_point(-32768, 32767);
    add_point(-1, 2048); add_point(2047, -1025); add_point(16'h5555, 16'haaaa);
    add_point(16'haaaa, 16'h5555);
    drain();

    // collapsed quad: every line has zero length
    for (int r = REG_CORNER_TL; r <= REG_CORNER_BL; r++)
      write_reg(CFG_IDX_W'(r), 32'h0123_0456);
    add_point(0, 0); add_point(700, 300); add_point(-32768, 32767);
    drain();
    // extreme corners, tiny rectangle, points far out
    write_reg(REG_RECT_WIDTH, 32'd1); write_reg(REG_RECT_HEIGHT, 32'd1);
    drain();
    write_reg(REG_CORNER_TL, 32'h8000_8000); write_reg(REG_CORNER_TR, 32'h7fff_8000);
    write_reg(REG_CORNER_BR, 32'h7fff_7fff); write_reg(REG_CORNER_BL, 32'h8000_7fff);
    add_point(0, 0); add_point(1, 1); add_point(32767, -32768); add_point(-32768, 32767);
    add_point(-2, 3); add_point(0, 1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 25 : (ph < 6) ? 81 : 0;
      mode = ph % 3;
      // rectangle setting, extremes in some phases
      case (ph)
        0: begin w = 1; h = 1; end
        4: begin w = 65535; h = 65535; end
        7: begin w = 65535; h = 1; end
        default: begin w = $urandom_range(1, 2048); h = $urandom_range(1, 2048); end
      endcase
      x0 = (ph == 4) ? -32768 : (ph == 7) ? 32767 : $urandom_range(0, 65535);
      y0 = (ph == 4) ? -32768 : (ph == 1) ? 32767 : $urandom_range(0, 65535);
      write_reg(REG_RECT_LEFT, x0);
      write_reg(REG_RECT_TOP, y0);
      write_reg(REG_RECT_WIDTH, w);
      write_reg(REG_RECT_HEIGHT, h);
      for (int r = REG_CORNER_TL; r <= REG_CORNER_BL; r++)
        write_reg(CFG_IDX_W'(r), rand_corner(mode));
      // parallel lines: three corners put on one line in one phase
      if (ph == 5) begin
        c = rand_corner(2);
        write_reg(REG_CORNER_TL, 32'h0000_0000); write_reg(REG_CORNER_TR, 32'h0100_0000);
        write_reg(REG_CORNER_BR, 32'h0200_0000); write_reg(REG_CORNER_BL, c);
      end
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(99) < 75)
          add_point(x0 + $urandom_range(0, w), y0 + $urandom_range(0, h));
        else
          add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      drain();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/qwp_pkg.sv
hdl/qwp_div_pipe.sv
hdl/qwp_geom.sv
hdl/quad_warp_point_map_unit.sv
dv/testbench.sv
